/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the normalisation factor rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define AST_IMPL(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/sphn_pkg.sv */
// ----------------------------------------------------------------------------
// sphn_pkg
// types and constants of the normalisation factor core
// ----------------------------------------------------------------------------
package sphn_pkg;

    localparam int FIELD_W = 11;
    localparam int EXP_W   = 13;

    // correctly rounded sqrt(2): significand and biased exponent
    localparam logic [52:0] SQRT2_SIG = 53'h16A09E667F3BCD;
    localparam logic [10:0] SQRT2_EXP = 11'd1023;

    localparam logic signed [EXP_W-1:0] SQ_EXP_OFS  = 13'sd1049;
    localparam logic signed [EXP_W-1:0] DV_EXP_OFS  = 13'sd52;
    localparam logic signed [EXP_W-1:0] EXP_OFS     = 13'sd1075;
    localparam logic signed [EXP_W-1:0] SUBN_EXP    = -13'sd1074;
    localparam logic signed [EXP_W-1:0] MIN_ACC_EXP = -13'sd1127;
    localparam logic signed [EXP_W-1:0] ACC_EXP_OFS = 13'sd1127;

    localparam logic [6:0] SQ_STEPS  = 7'd54;
    localparam logic [6:0] DIV_BITS  = 7'd54;
    localparam logic [6:0] MUL_STEPS = 7'd53;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_NORM,
        ST_SQP,
        ST_SQ,
        ST_LOOP,
        ST_DIV,
        ST_MULP,
        ST_MUL,
        ST_MNORM,
        ST_MDEN,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_NORM_STEP,
        OP_SQ_PREP,
        OP_SQ_STEP,
        OP_SQ_FIN,
        OP_PROD,
        OP_DIV_STEP,
        OP_DIV_FIN,
        OP_LOAD_SQRT2,
        OP_MUL_PREP,
        OP_MUL_STEP,
        OP_MNORM_STEP,
        OP_MDEN_STEP,
        OP_MFIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   to_f;
    } dp_cmd_t;

    typedef struct packed {
        logic err;
        logic norm_ok;
        logic sq_end;
        logic k_le_m;
        logic m_nz;
        logic div_end;
        logic mul_end;
        logic mnorm_end;
        logic mden_end;
    } dp_status_t;

endpackage

/* rtl/sphn_datapath.sv */
// ----------------------------------------------------------------------------
// sphn_datapath
// serial reciprocal, square root and multiplier with rounding, under command
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sphn_datapath
    import sphn_pkg::*;
#(
    parameter int DEGREE_BOUND = 2047
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [FIELD_W-1:0] degree,
    input  logic [FIELD_W-1:0] order,
    input  logic               cfg_we,
    input  logic [FIELD_W-1:0] cfg_wdata,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output logic [63:0]        factor_bits,
    output logic               range_error
);

    logic [FIELD_W-1:0]      max_degree_reg;
    logic [FIELD_W-1:0]      l_reg;
    logic [FIELD_W-1:0]      m_reg;
    logic [FIELD_W:0]        k_reg;
    logic                    err_reg;
    logic [6:0]              cnt_reg;

    logic [52:0]             sq_mant_reg;
    logic signed [EXP_W-1:0] sq_e_reg;
    logic [107:0]            sq_x_reg;
    logic [55:0]             sq_rem_reg;
    logic [53:0]             sq_root_reg;

    logic [52:0]             s_sig_reg;
    logic [10:0]             s_exp_reg;
    logic [63:0]             f_reg;

    logic [22:0]             p_reg;
    logic [22:0]             dv_rem_reg;
    logic [53:0]             dv_q_reg;
    logic [5:0]              dv_j_reg;
    logic                    dv_started_reg;

    logic [52:0]             mu_a_reg;
    logic [52:0]             mu_b_reg;
    logic [105:0]            acc_reg;
    logic signed [EXP_W-1:0] mx_reg;

    logic                    load_err;
    logic [53:0]             sq_adj;
    logic [57:0]             sq_rs;
    logic [57:0]             sq_trial;
    logic                    sq_ge;
    logic [57:0]             sq_diff;
    logic                    sq_inc;
    logic [53:0]             sq_r;
    logic signed [EXP_W-1:0] sq_eo;
    logic [52:0]             sq_sig;

    logic [11:0]             pa;
    logic [11:0]             pb;
    logic [23:0]             pp;
    logic [23:0]             dv_rs;
    logic                    dv_ge;
    logic [23:0]             dv_sub;
    logic                    dv_up;
    logic [53:0]             dv_sum;
    logic [52:0]             dv_mant;
    logic signed [EXP_W-1:0] dv_e;

    logic [10:0]             f_exp;
    logic [52:0]             mu_a_init;
    logic signed [EXP_W-1:0] ea;
    logic signed [EXP_W-1:0] eb;
    logic [105:0]            acc_add;
    logic                    acc_zero;
    logic                    mu_up;
    logic [53:0]             mu_r;
    logic signed [EXP_W-1:0] mu_ex;
    logic [63:0]             mu_bits;

    assign load_err = (order > degree) || (degree > max_degree_reg)
                      || (32'(degree) > DEGREE_BOUND);

    // square root, two radicand bits a step
    assign sq_adj   = sq_e_reg[0] ? {sq_mant_reg, 1'b0} : {1'b0, sq_mant_reg};
    assign sq_rs    = {sq_rem_reg, sq_x_reg[107:106]};
    assign sq_trial = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge    = sq_rs >= sq_trial;
    assign sq_diff  = sq_rs - sq_trial;
    assign sq_inc   = sq_root_reg[0] && ((sq_rem_reg != '0) || sq_root_reg[1]);
    assign sq_r     = {1'b0, sq_root_reg[53:1]} + 54'(sq_inc);
    assign sq_eo    = (sq_e_reg >>> 1) + SQ_EXP_OFS + EXP_W'(sq_r[53]);
    assign sq_sig   = sq_r[53] ? sq_r[53:1] : sq_r[52:0];

    // exact integer product and reciprocal, one quotient bit a step
    assign pa      = 12'({1'b0, l_reg} - k_reg + 12'd1);
    assign pb      = 12'({1'b0, l_reg} + k_reg);
    assign pp      = pa * pb;
    assign dv_rs   = {dv_rem_reg, 1'b0};
    assign dv_ge   = dv_rs >= {1'b0, p_reg};
    assign dv_sub  = dv_rs - {1'b0, p_reg};
    assign dv_up   = dv_q_reg[0] && ((dv_rem_reg != '0) || dv_q_reg[1]);
    assign dv_sum  = {1'b0, dv_q_reg[53:1]} + 54'(dv_up);
    assign dv_mant = dv_sum[53] ? dv_sum[53:1] : dv_sum[52:0];
    assign dv_e    = EXP_W'(dv_sum[53]) - EXP_W'(dv_j_reg) - DV_EXP_OFS;

    // shift-add multiplier with subnormal rounding
    assign f_exp     = f_reg[62:52];
    assign mu_a_init = {(f_exp != '0), f_reg[51:0]};
    assign ea        = (f_exp == '0) ? SUBN_EXP : EXP_W'(f_exp) - EXP_OFS;
    assign eb        = EXP_W'(s_exp_reg) - EXP_OFS;
    assign acc_add   = {acc_reg[104:0], 1'b0} + (mu_b_reg[52] ? {53'b0, mu_a_reg} : '0);
    assign acc_zero  = acc_reg == '0;
    assign mu_up     = acc_reg[52] && ((acc_reg[51:0] != '0) || acc_reg[53]);
    assign mu_r      = {1'b0, acc_reg[105:53]} + 54'(mu_up);
    assign mu_ex     = mx_reg + ACC_EXP_OFS;
    assign mu_bits   = {1'b0, mu_ex[10:0], 52'b0} + {10'b0, mu_r};

    always_comb
    begin
        status.err       = err_reg;
        status.norm_ok   = sq_mant_reg[52];
        status.sq_end    = cnt_reg == '0;
        status.k_le_m    = k_reg <= {1'b0, m_reg};
        status.m_nz      = m_reg != '0;
        status.div_end   = dv_started_reg && (cnt_reg == DIV_BITS);
        status.mul_end   = cnt_reg == '0;
        status.mnorm_end = acc_zero || acc_reg[105];
        status.mden_end  = acc_zero || (mx_reg >= MIN_ACC_EXP);
    end

    assign factor_bits = err_reg ? '0 : f_reg;
    assign range_error = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_degree_reg <= '0;
        end
        else if (cfg_we)
        begin
            max_degree_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                l_reg       <= degree;
                m_reg       <= order;
                k_reg       <= 12'd1;
                err_reg     <= load_err;
                sq_mant_reg <= {41'b0, degree, 1'b1};
                sq_e_reg    <= '0;
            end
            OP_NORM_STEP:
            begin
                sq_mant_reg <= {sq_mant_reg[51:0], 1'b0};
                sq_e_reg    <= sq_e_reg - 13'sd1;
            end
            OP_SQ_PREP:
            begin
                sq_x_reg    <= {sq_adj, 54'b0};
                sq_e_reg    <= sq_e_reg - EXP_W'(sq_e_reg[0]);
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
                cnt_reg     <= SQ_STEPS;
            end
            OP_SQ_STEP:
            begin
                sq_x_reg    <= {sq_x_reg[105:0], 2'b00};
                sq_rem_reg  <= sq_ge ? sq_diff[55:0] : sq_rs[55:0];
                sq_root_reg <= {sq_root_reg[52:0], sq_ge};
                cnt_reg     <= cnt_reg - 7'd1;
            end
            OP_SQ_FIN:
            begin
                s_sig_reg <= sq_sig;
                s_exp_reg <= sq_eo[10:0];
                if (cmd.to_f)
                begin
                    f_reg <= {1'b0, sq_eo[10:0], sq_sig[51:0]};
                end
            end
            OP_PROD:
            begin
                p_reg          <= pp[22:0];
                k_reg          <= k_reg + 12'd1;
                dv_rem_reg     <= 23'd1;
                dv_q_reg       <= '0;
                dv_j_reg       <= '0;
                dv_started_reg <= 1'b0;
                cnt_reg        <= '0;
            end
            OP_DIV_STEP:
            begin
                dv_rem_reg <= dv_ge ? dv_sub[22:0] : dv_rs[22:0];
                if (!dv_started_reg)
                begin
                    dv_j_reg <= dv_j_reg + 6'd1;
                    if (dv_ge)
                    begin
                        dv_started_reg <= 1'b1;
                        dv_q_reg       <= 54'd1;
                        cnt_reg        <= 7'd1;
                    end
                end
                else
                begin
                    dv_q_reg <= {dv_q_reg[52:0], dv_ge};
                    cnt_reg  <= cnt_reg + 7'd1;
                end
            end
            OP_DIV_FIN:
            begin
                sq_mant_reg <= dv_mant;
                sq_e_reg    <= dv_e;
            end
            OP_LOAD_SQRT2:
            begin
                s_sig_reg <= SQRT2_SIG;
                s_exp_reg <= SQRT2_EXP;
            end
            OP_MUL_PREP:
            begin
                mu_a_reg <= mu_a_init;
                mu_b_reg <= s_sig_reg;
                mx_reg   <= ea + eb;
                acc_reg  <= '0;
                cnt_reg  <= MUL_STEPS;
            end
            OP_MUL_STEP:
            begin
                acc_reg  <= acc_add;
                mu_b_reg <= {mu_b_reg[51:0], 1'b0};
                cnt_reg  <= cnt_reg - 7'd1;
            end
            OP_MNORM_STEP:
            begin
                acc_reg <= {acc_reg[104:0], 1'b0};
                mx_reg  <= mx_reg - 13'sd1;
            end
            OP_MDEN_STEP:
            begin
                acc_reg <= {1'b0, acc_reg[105:2], acc_reg[1] | acc_reg[0]};
                mx_reg  <= mx_reg + 13'sd1;
            end
            OP_MFIN:
            begin
                f_reg <= acc_zero ? '0 : mu_bits;
            end
            default:
            begin
            end
        endcase
    end

    `AST_IMPL(a_sq_step_count, cmd.op == OP_SQ_STEP, cnt_reg != '0)
    `AST_IMPL(a_div_fin_norm, cmd.op == OP_DIV_FIN, dv_started_reg && dv_q_reg[53])

endmodule

/* rtl/sphn_ctrl.sv */
// ----------------------------------------------------------------------------
// sphn_ctrl
// sequencer for the normalisation factor recursion
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sphn_ctrl
    import sphn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        first_reg;
    logic        first_next;
    logic        final_reg;
    logic        final_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            final_reg <= final_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        final_next = final_reg;
        cmd.op     = OP_NONE;
        cmd.to_f   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    first_next = 1'b1;
                    final_next = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.err ? ST_DONE : ST_NORM;
            end
            ST_NORM:
            begin
                if (status.norm_ok)
                begin
                    state_next = ST_SQP;
                end
                else
                begin
                    cmd.op = OP_NORM_STEP;
                end
            end
            ST_SQP:
            begin
                cmd.op     = OP_SQ_PREP;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                if (status.sq_end)
                begin
                    cmd.op     = OP_SQ_FIN;
                    cmd.to_f   = first_reg;
                    first_next = 1'b0;
                    state_next = first_reg ? ST_LOOP : ST_MULP;
                end
                else
                begin
                    cmd.op = OP_SQ_STEP;
                end
            end
            ST_LOOP:
            begin
                priority if (status.k_le_m)
                begin
                    cmd.op     = OP_PROD;
                    state_next = ST_DIV;
                end
                else if (status.m_nz)
                begin
                    cmd.op     = OP_LOAD_SQRT2;
                    final_next = 1'b1;
                    state_next = ST_MULP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (status.div_end)
                begin
                    cmd.op     = OP_DIV_FIN;
                    state_next = ST_SQP;
                end
                else
                begin
                    cmd.op = OP_DIV_STEP;
                end
            end
            ST_MULP:
            begin
                cmd.op     = OP_MUL_PREP;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (status.mul_end)
                begin
                    state_next = ST_MNORM;
                end
                else
                begin
                    cmd.op = OP_MUL_STEP;
                end
            end
            ST_MNORM:
            begin
                if (status.mnorm_end)
                begin
                    state_next = ST_MDEN;
                end
                else
                begin
                    cmd.op = OP_MNORM_STEP;
                end
            end
            ST_MDEN:
            begin
                if (status.mden_end)
                begin
                    cmd.op     = OP_MFIN;
                    state_next = final_reg ? ST_DONE : ST_LOOP;
                end
                else
                begin
                    cmd.op = OP_MDEN_STEP;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = state_reg != ST_IDLE;
    assign done = state_reg == ST_DONE;

    `AST_NEXT(a_done_single, done, !done)
    `AST_NEXT(a_accept_busy, start && !busy, busy && !done)

endmodule

/* rtl/sph_harmonic_norm_const_core.sv */
// ----------------------------------------------------------------------------
// sph_harmonic_norm_const_core
// spherical-harmonic normalisation factor as an ieee double, per request
// ----------------------------------------------------------------------------
// channel   | signals                        | transfer
// ----------|--------------------------------|---------------------------------
// request   | start, busy, degree, order     | edge with start high, busy low
// result    | done, factor_bits, range_error | edge ending the done cycle
// config    | cfg_we, cfg_wdata (max_degree) | edge with cfg_we high
//
// a rejected request goes from check straight to done; order 0 needs only the
// square root, and each order step adds the serial reciprocal, the two-bit-a-step
// root and the bit-serial 53x53 multiplier, with denormalising steps once the
// factor is subnormal; a nonzero order ends with a multiply by sqrt(2)
// one request at a time; busy stays high until the done cycle has passed
// reset clears the sequencer and max_degree; the receiver cannot stall
// ----------------------------------------------------------------------------
module sph_harmonic_norm_const_core
    import sphn_pkg::*;
#(
    parameter int DEGREE_BOUND = 2047
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FIELD_W-1:0] degree,
    input  logic [FIELD_W-1:0] order,
    input  logic               cfg_we,
    input  logic [FIELD_W-1:0] cfg_wdata,
    output logic               done,
    output logic [63:0]        factor_bits,
    output logic               range_error
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sphn_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    sphn_datapath #(
        .DEGREE_BOUND (DEGREE_BOUND)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .degree      (degree),
        .order       (order),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .status      (status),
        .factor_bits (factor_bits),
        .range_error (range_error)
    );

endmodule

/* verif/tb_sph_harmonic_norm_const_core.sv */
// ----------------------------------------------------------------------------
// tb_sph_harmonic_norm_const_core
// self-checking bench for the normalisation factor core: each accepted
// request is predicted in double arithmetic and every done transfer is
// checked against the oldest prediction; max_degree is changed while idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sph_harmonic_norm_const_core;
    import sphn_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [63:0] factor_bits;
        logic        range_error;
    } norm_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [FIELD_W-1:0] degree = '0;
    logic [FIELD_W-1:0] order = '0;
    logic               cfg_we = 1'b0;
    logic [FIELD_W-1:0] cfg_wdata = '0;
    logic               done;
    logic [63:0]        factor_bits;
    logic               range_error;

    logic [FIELD_W-1:0] max_degree_model = '0;
    norm_result_t       pending_factors[$];
    int                 fail_count = 0;
    int                 cycle_count = 0;

    sph_harmonic_norm_const_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .degree      (degree),
        .order       (order),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .factor_bits (factor_bits),
        .range_error (range_error)
    );

    always #5 clk = ~clk;

    function automatic norm_result_t norm_factor(input int l, input int m, input int maxd);
        norm_result_t r;
        real f;
        int p;
        r.factor_bits = '0;
        r.range_error = 1'b1;
        if (m <= l && l <= maxd)
        begin
            f = $sqrt(real'(2 * l + 1));
            for (int k = 1; k <= m; k++)
            begin
                p = (l - k + 1) * (l + k);
                f = f * $sqrt(1.0 / real'(p));
            end
            if (m > 0)
                f = f * $sqrt(2.0);
            r.factor_bits = $realtobits(f);
            r.range_error = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_sph_harmonic_norm_const_core failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        norm_result_t want;
        if (rst_n && done)
        begin
            if (pending_factors.size() == 0)
            begin
                $error("unexpected result transfer");
                fail_count++;
            end
            else
            begin
                want = pending_factors.pop_front();
                if (factor_bits !== want.factor_bits)
                begin
                    $error("factor_bits expected %h actual %h", want.factor_bits, factor_bits);
                    fail_count++;
                end
                if (range_error !== want.range_error)
                begin
                    $error("range_error expected %b actual %b", want.range_error, range_error);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_request(input int l, input int m);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        degree = l[FIELD_W-1:0];
        order  = m[FIELD_W-1:0];
        start  = 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_factors.push_back(norm_factor(l, m, max_degree_model));
        @(negedge clk);
    endtask

    task automatic drain_results();
        start = 1'b0;
        while (pending_factors.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_max_degree(input int value);
        drain_results();
        cfg_wdata = value[FIELD_W-1:0];
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        max_degree_model = value[FIELD_W-1:0];
        @(negedge clk);
    endtask

    task automatic test_reset_default();
        send_request(0, 0);
        send_request(1, 0);
        send_request(0, 1);
        send_request(0, 2047);
    endtask

    task automatic test_directed();
        write_max_degree(2047);
        send_request(2047, 0);
        send_request(2047, 1);
        send_request(2046, 2047);
        send_request(1, 1);
        send_request(5, 5);
        send_request(2047, 40);
        send_request(1024, 3);
        send_request(0, 0);
        write_max_degree(10);
        send_request(10, 3);
        send_request(10, 10);
        send_request(11, 0);
        send_request(2047, 0);
        send_request(3, 4);
    endtask

    task automatic random_phase(input int maxd, input int count);
        int l;
        int m;
        int sel;
        write_max_degree(maxd);
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 15)
            begin
                l = $urandom_range(0, 2047);
                m = $urandom_range(0, 2047);
                if (m <= l && m > 3)
                    m = l + 1 > 2047 ? 0 : 2047;
                if (m <= l && l <= maxd && m > 3)
                    m = 3;
            end
            else if (sel < 25)
            begin
                l = $urandom_range(0, 2046);
                m = $urandom_range(l + 1, 2047);
            end
            else
            begin
                l = $urandom_range(0, maxd);
                m = (sel < 30) ? $urandom_range(0, 30) : $urandom_range(0, 3);
                if (m > l)
                    m = l;
            end
            send_request(l, m);
            if (sel == 50)
                drain_results();
        end
    endtask

    task automatic test_random();
        random_phase(2047, 300);
        random_phase($urandom_range(1, 2046), 150);
        random_phase(0, 50);
        random_phase(2047, 100);
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_default();
        test_directed();
        test_random();
        drain_results();
        if (fail_count == 0)
            $display("tb_sph_harmonic_norm_const_core passed");
        else
            $display("tb_sph_harmonic_norm_const_core failed");
        $finish;
    end

endmodule
